@@ hw/rtl/timestamp_priority_request_table_top_macros.svh @@
// Assertion macros for the timestamp priority request table.
// Used by the RTL modules that carry concurrent assertions; no other dependencies.
`ifndef TIMESTAMP_PRIORITY_REQUEST_TABLE_TOP_MACROS_SVH
`define TIMESTAMP_PRIORITY_REQUEST_TABLE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSPR_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSPR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/tspr_pkg.sv @@
// Shared types and constants of the timestamp priority request table.
// No dependencies; imported by every RTL module of the block.
package tspr_pkg;

   localparam int ID_W    = 7;
   localparam int STAMP_W = 15;
   localparam int COUNT_W = 5;
   localparam int FUNC_W  = 2;
   localparam int ERR_W   = 2;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

   localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
   localparam logic [ERR_W-1:0] ERR_FULL      = 2'd1;
   localparam logic [ERR_W-1:0] ERR_EMPTY     = 2'd2;
   localparam logic [ERR_W-1:0] ERR_NOT_FOUND = 2'd3;

   localparam logic [ID_W-1:0]    SENTINEL_ID    = 7'd127;
   localparam logic [STAMP_W-1:0] SENTINEL_STAMP = 15'd32767;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic               is_lowest;
      logic [ERR_W-1:0]   error_code;
      logic [COUNT_W-1:0] entry_count;
   } result_type;

endpackage

@@ hw/rtl/tspr_mem.sv @@
// Entry memory of the request table: one write port, one read port, registered read data.
// Depends on tspr_pkg for the entry type.
module tspr_mem #(
   parameter int TABLE_DEPTH = 16,
   parameter int AW          = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  tspr_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output tspr_pkg::entry_type rd_data_ff
);
   import tspr_pkg::*;

   entry_type mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

@@ hw/rtl/tspr_ctrl.sv @@
// Sequencer of the request table: insert, remove with gap closing, and minimum query.
// Depends on tspr_pkg and on the macro header; drives the entry memory in tspr_mem.
`include "timestamp_priority_request_table_top_macros.svh"

module tspr_ctrl #(
   parameter int TABLE_DEPTH = 16,
   parameter int AW          = 4,
   parameter int CW          = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tspr_pkg::FUNC_W-1:0] req_func,
   input  tspr_pkg::entry_type         req_entry,
   output logic                        res_valid,
   input  logic                        res_ready,
   output tspr_pkg::result_type        res_data,
   output logic                        wr_en,
   output logic [AW-1:0]               wr_addr,
   output tspr_pkg::entry_type         wr_data,
   output logic [AW-1:0]               rd_addr,
   input  tspr_pkg::entry_type         rd_data
);
   import tspr_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   logic [1:0]         state_ff, state_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [FUNC_W-1:0]  func_ff, func_in;
   entry_type          req_ff, req_in;
   logic [CW-1:0]      iss_ff, iss_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      chk_ff, chk_in;
   logic               found_ff, found_in;
   entry_type          min_ff, min_in;
   logic               lowest_ff, lowest_in;
   logic [ERR_W-1:0]   err_ff, err_in;
   logic               issue;
   logic               scan_done;

   assign issue     = (state_ff == ST_SCAN) && (iss_ff < fill_ff);
   assign scan_done = (state_ff == ST_SCAN) && !issue && !pend_ff;
   assign rd_addr   = iss_ff[AW-1:0];
   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);

   always_comb begin
      res_data.is_lowest   = lowest_ff;
      res_data.error_code  = err_ff;
      res_data.entry_count = COUNT_W'(fill_ff);
   end

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      func_in   = func_ff;
      req_in    = req_ff;
      iss_in    = iss_ff;
      pend_in   = pend_ff;
      chk_in    = chk_ff;
      found_in  = found_ff;
      min_in    = min_ff;
      lowest_in = lowest_ff;
      err_in    = err_ff;
      wr_en     = 1'b0;
      wr_addr   = fill_ff[AW-1:0];
      wr_data   = req_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               req_in   = req_entry;
               state_in = ST_START;
            end
         end
         ST_START: begin
            lowest_in = 1'b0;
            err_in    = ERR_OK;
            iss_in    = '0;
            pend_in   = 1'b0;
            found_in  = 1'b0;
            min_in.id    = SENTINEL_ID;
            min_in.stamp = SENTINEL_STAMP;
            case (func_ff)
               FUNC_INSERT: begin
                  state_in = ST_DONE;
                  if (fill_ff == FULL_COUNT) begin
                     err_in = ERR_FULL;
                  end else begin
                     wr_en   = 1'b1;
                     fill_in = CW'(fill_ff + 1'b1);
                  end
               end
               FUNC_REMOVE: begin
                  if (fill_ff == '0) begin
                     err_in   = ERR_EMPTY;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               FUNC_QUERY: begin
                  state_in = ST_SCAN;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_SCAN: begin
            pend_in = issue;
            if (issue) begin
               iss_in = CW'(iss_ff + 1'b1);
               chk_in = iss_ff[AW-1:0];
            end
            if (pend_ff) begin
               if (func_ff == FUNC_REMOVE) begin
                  if (found_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = AW'(chk_ff - 1'b1);
                     wr_data = rd_data;
                  end else if (rd_data.id == req_ff.id) begin
                     found_in = 1'b1;
                  end
               end else if ((rd_data.stamp < min_ff.stamp) ||
                            ((rd_data.stamp == min_ff.stamp) && (rd_data.id < min_ff.id))) begin
                  min_in = rd_data;
               end
            end
            if (scan_done) begin
               state_in = ST_DONE;
               if (func_ff == FUNC_REMOVE) begin
                  if (found_ff) begin
                     fill_in = CW'(fill_ff - 1'b1);
                  end else begin
                     err_in = ERR_NOT_FOUND;
                  end
               end else begin
                  lowest_in = (req_ff == min_ff);
               end
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      req_ff    <= req_in;
      iss_ff    <= iss_in;
      chk_ff    <= chk_in;
      min_ff    <= min_in;
      lowest_ff <= lowest_in;
      err_ff    <= err_in;
   end

   `TSPR_ASSERT_SAME(a_fill_bound, clock, reset, 1'b1, fill_ff <= FULL_COUNT, "fill count above table depth")
   `TSPR_ASSERT_SAME(a_write_state, clock, reset, wr_en, (state_ff == ST_START) || (state_ff == ST_SCAN), "memory write outside an operation")
   `TSPR_ASSERT_NEXT(a_accept_start, clock, reset, (state_ff == ST_IDLE) && req_valid, state_ff == ST_START, "accepted request did not start")

endmodule

@@ hw/rtl/timestamp_priority_request_table_top.sv @@
// Path of a request: ST_START, then for a query, or a remove on a non-empty table, ST_SCAN
// reading each held entry, then ST_DONE and the result register that drives the response.
// One request at a time: the next one is taken once the result has left ST_DONE, and the
// time per request is set by the single read port of the entry memory that the scan walks.
// Reset is synchronous and clears the fill count; the entry memory is not cleared.
// Top level: stream ports, result register, tspr_ctrl sequencer and tspr_mem storage.
module timestamp_priority_request_table_top #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // process_id [6:0], stamp [21:7], zero [23:22]
   input  logic [1:0]  req_tuser,  // func [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // is_lowest [0], error_code [2:1], entry_count [7:3]
);
   import tspr_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   entry_type  req_entry;
   logic       res_valid;
   logic       res_ready;
   result_type res_data;
   logic       wr_en;
   logic [AW-1:0] wr_addr;
   entry_type  wr_data;
   logic [AW-1:0] rd_addr;
   entry_type  rd_data;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;

   assign req_entry.id    = req_tdata[ID_W-1:0];
   assign req_entry.stamp = req_tdata[ID_W+STAMP_W-1:ID_W];

   tspr_ctrl #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .AW         (AW),
      .CW         (CW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_func (req_tuser),
      .req_entry(req_entry),
      .res_valid(res_valid),
      .res_ready(res_ready),
      .res_data (res_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   tspr_mem #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .AW         (AW)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data_ff(rd_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.entry_count, rsp_data_ff.error_code, rsp_data_ff.is_lowest};

endmodule
